FILE: design/first_fit_unit_map_allocator_macros.svh
// Assertion shorthands shared by the allocator RTL.
// Each samples on posedge clk and is off while rst_n is low.
`ifndef FIRST_FIT_UNIT_MAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_UNIT_MAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define FFUM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FFUM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ffum_pkg.sv
`timescale 1ns / 1ps

package ffum_pkg;

    // Marks per memory word and the bits that select one of them.
    localparam int WORD_BITS = 16;
    localparam int POS_W     = 4;

    // Width of unit_count, also used for run lengths.
    localparam int CNT_W = 11;

    localparam logic [31:0] DATA_BASE_RESET = 32'h010F_F7FF;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_DONE
    } state_t;

    // Per-word search result.
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] carry_out;
    } eval_t;

endpackage

FILE: design/ffum_ram.sv
`timescale 1ns / 1ps

module ffum_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/ffum_word_eval.sv
`timescale 1ns / 1ps

// One word of the first-fit search: run length ending at each bit,
// lowest bit that closes a long enough run, and the run carried out.
module ffum_word_eval (
    input  logic [ffum_pkg::WORD_BITS-1:0] free_bits,
    input  logic [ffum_pkg::CNT_W-1:0]     carry_in,
    input  logic [ffum_pkg::CNT_W-1:0]     need,
    output ffum_pkg::eval_t                res
);

    logic [ffum_pkg::CNT_W-1:0] run [ffum_pkg::WORD_BITS];

    // Per bit: distance back to the nearest used bit, or carry + j + 1 when none.
    always_comb
    begin
        logic                       seen;
        logic [ffum_pkg::POS_W-1:0] last_used;
        for (int j = 0; j < ffum_pkg::WORD_BITS; j++)
        begin
            seen      = 1'b0;
            last_used = '0;
            for (int i = 0; i <= j; i++)
            begin
                if (!free_bits[i])
                begin
                    seen      = 1'b1;
                    last_used = ffum_pkg::POS_W'(i);
                end
            end
            if (seen)
            begin
                run[j] = ffum_pkg::CNT_W'(j) - ffum_pkg::CNT_W'(last_used);
            end
            else
            begin
                run[j] = carry_in + ffum_pkg::CNT_W'(j + 1);
            end
        end
    end

    always_comb
    begin
        res.hit = 1'b0;
        res.pos = '0;
        for (int j = ffum_pkg::WORD_BITS - 1; j >= 0; j--)
        begin
            if (free_bits[j] && (run[j] >= need))
            begin
                res.hit = 1'b1;
                res.pos = ffum_pkg::POS_W'(j);
            end
        end
        res.carry_out = run[ffum_pkg::WORD_BITS-1];
    end

endmodule

FILE: design/first_fit_unit_map_allocator.sv
`timescale 1ns / 1ps
`include "first_fit_unit_map_allocator_macros.svh"

// First-fit allocator over a map of NUM_UNITS used marks, held 16 marks to
// a word in a one-port-read, one-port-write RAM. A request is taken when
// start is high and busy is low; its result appears on success, found_index
// and data_address for exactly one cycle with done high, and must be taken
// then, since the block never waits on the receiver. Every request gives one
// result. An allocate scans the map words and then marks the run that it
// found; a zero size or failed search skips the marking pass, and an
// oversized count skips both. A free clears the marks in its range; an
// empty or out-of-map free skips that pass. A clear sweeps every word.
// Each pass walks the map RAM a word at a time: one read issued per cycle,
// one word checked or rewritten per cycle.
// After reset the map is cleared by the same pass with busy high and no
// result; data_base may be written meanwhile. data_base is to be written
// only while the block is idle; the block itself does not enforce this.
module first_fit_unit_map_allocator #(
    parameter int NUM_UNITS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [10:0] unit_count,
    input  logic [9:0]  free_index,

    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,

    output logic        done,
    output logic        success,
    output logic [9:0]  found_index,
    output logic [31:0] data_address
);

    localparam int WB     = ffum_pkg::WORD_BITS;
    localparam int PW     = ffum_pkg::POS_W;
    localparam int CW     = ffum_pkg::CNT_W;
    localparam int WORDS  = (NUM_UNITS + WB - 1) / WB;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BIT_W  = ADDR_W + PW;
    // Wide enough for NUM_UNITS itself and for free_index + unit_count.
    localparam int XW     = (BIT_W + 1 > 12) ? BIT_W + 1 : 12;
    localparam int LAST_WORD = WORDS - 1;
    localparam int LAST_BITS = NUM_UNITS - LAST_WORD * WB;

    localparam logic [XW-1:0]     NUM_X    = XW'(NUM_UNITS);
    localparam logic [ADDR_W:0]   WORDS_P  = (ADDR_W + 1)'(WORDS);
    localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(LAST_WORD);
    localparam logic [BIT_W-1:0]  MAP_TOP  = BIT_W'(WORDS * WB - 1);

    ffum_pkg::state_t state_reg, state_next;

    logic              init_reg, init_next;      // power-up clearing pass
    logic [ADDR_W:0]   ptr_reg, ptr_next;        // next word to read
    logic [ADDR_W-1:0] eval_ptr_reg, eval_ptr_next; // word in rd_data
    logic              pend_reg, pend_next;      // rd_data holds a word
    logic [CW-1:0]     carry_reg, carry_next;    // free run entering word
    logic [CW-1:0]     eff_reg, eff_next;        // run length needed (>= 1)
    logic              zero_reg, zero_next;      // zero-size allocate
    logic [BIT_W-1:0]  lo_reg, lo_next;          // sweep range, also start
    logic [BIT_W-1:0]  hi_reg, hi_next;
    logic              set_reg, set_next;        // sweep writes 1s or 0s
    logic              full_reg, full_next;      // sweep clears whole words
    logic              res_ok_reg, res_ok_next;
    logic              res_hit_reg, res_hit_next;
    logic [31:0]       data_base_reg;

    logic              accept;
    logic              ram_re, ram_we;
    logic [WB-1:0]     rd_data, wr_data;
    logic [WB-1:0]     free_bits, mask;
    logic [ADDR_W-1:0] lo_word, hi_word;
    logic [BIT_W-1:0]  hit_bit;
    ffum_pkg::eval_t   ev;

    logic [XW-1:0]     first_x, end_x, count_x;

    assign accept  = start && !busy;
    assign lo_word = lo_reg[BIT_W-1:PW];
    assign hi_word = hi_reg[BIT_W-1:PW];
    assign hit_bit = {eval_ptr_reg, ev.pos};

    assign first_x = XW'(free_index);
    assign count_x = XW'(unit_count);
    assign end_x   = first_x + count_x - XW'(1);

    // ------------------------------------------------------------------
    // Map storage
    // ------------------------------------------------------------------
    ffum_ram #(
        .WIDTH (WB),
        .DEPTH (WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (eval_ptr_reg),
        .wdata (wr_data),
        .re    (ram_re),
        .raddr (ptr_reg[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    // Bits past the map end in the last word count as used.
    always_comb
    begin
        for (int b = 0; b < WB; b++)
        begin
            free_bits[b] = ((eval_ptr_reg != LAST_A) || (b < LAST_BITS)) && !rd_data[b];
        end
    end

    ffum_word_eval u_eval (
        .free_bits (free_bits),
        .carry_in  (carry_reg),
        .need      (eff_reg),
        .res       (ev)
    );

    // Sweep mask: bits of this word inside [lo, hi], or all bits when full_reg is set.
    always_comb
    begin
        for (int b = 0; b < WB; b++)
        begin
            mask[b] = full_reg
                   || (((eval_ptr_reg != lo_word) || (PW'(b) >= lo_reg[PW-1:0]))
                    && ((eval_ptr_reg != hi_word) || (PW'(b) <= hi_reg[PW-1:0])));
        end
    end

    assign wr_data = (rd_data & ~mask) | (set_reg ? mask : '0);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffum_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        ffum_pkg::CMD_ALLOC:
                        begin
                            state_next = (count_x > NUM_X) ? ffum_pkg::ST_DONE
                                                           : ffum_pkg::ST_SCAN;
                        end
                        ffum_pkg::CMD_FREE:
                        begin
                            state_next = ((unit_count == '0) || (first_x >= NUM_X))
                                       ? ffum_pkg::ST_DONE : ffum_pkg::ST_SWEEP;
                        end
                        ffum_pkg::CMD_CLEAR:
                        begin
                            state_next = ffum_pkg::ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = ffum_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            ffum_pkg::ST_SCAN:
            begin
                if (pend_reg)
                begin
                    if (ev.hit)
                    begin
                        state_next = zero_reg ? ffum_pkg::ST_DONE : ffum_pkg::ST_SWEEP;
                    end
                    else if (eval_ptr_reg == LAST_A)
                    begin
                        state_next = ffum_pkg::ST_DONE;
                    end
                end
            end
            ffum_pkg::ST_SWEEP:
            begin
                if (pend_reg && (eval_ptr_reg == hi_word))
                begin
                    state_next = init_reg ? ffum_pkg::ST_IDLE : ffum_pkg::ST_DONE;
                end
            end
            ffum_pkg::ST_DONE:
            begin
                state_next = ffum_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ffum_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs and RAM control
    // ------------------------------------------------------------------
    always_comb
    begin
        busy   = 1'b1;
        done   = 1'b0;
        ram_re = 1'b0;
        ram_we = 1'b0;
        case (state_reg)
            ffum_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            ffum_pkg::ST_SCAN:
            begin
                ram_re = (ptr_reg < WORDS_P);
            end
            ffum_pkg::ST_SWEEP:
            begin
                ram_re = (ptr_reg <= {1'b0, hi_word});
                ram_we = pend_reg;
            end
            ffum_pkg::ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign success      = res_ok_reg;
    assign found_index  = res_hit_reg ? 10'(lo_reg) : '0;
    assign data_address = res_hit_reg ? (data_base_reg + 32'(lo_reg)) : '0;

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_comb
    begin
        init_next     = init_reg;
        ptr_next      = ptr_reg;
        eval_ptr_next = eval_ptr_reg;
        pend_next     = pend_reg;
        carry_next    = carry_reg;
        eff_next      = eff_reg;
        zero_next     = zero_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        set_next      = set_reg;
        full_next     = full_reg;
        res_ok_next   = res_ok_reg;
        res_hit_next  = res_hit_reg;

        // Read pipeline: one word issued, one word landing.
        if (state_reg == ffum_pkg::ST_SCAN || state_reg == ffum_pkg::ST_SWEEP)
        begin
            pend_next = ram_re;
            if (ram_re)
            begin
                ptr_next      = ptr_reg + 1'b1;
                eval_ptr_next = ptr_reg[ADDR_W-1:0];
            end
        end

        case (state_reg)
            ffum_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    pend_next    = 1'b0;
                    carry_next   = '0;
                    eff_next     = (unit_count == '0) ? CW'(1) : unit_count;
                    zero_next    = (unit_count == '0);
                    full_next    = 1'b0;
                    set_next     = 1'b0;
                    res_hit_next = 1'b0;
                    res_ok_next  = 1'b1;
                    lo_next      = '0;
                    ptr_next     = '0;
                    case (command)
                        ffum_pkg::CMD_ALLOC:
                        begin
                            res_ok_next = 1'b0;
                        end
                        ffum_pkg::CMD_FREE:
                        begin
                            lo_next  = BIT_W'(first_x);
                            hi_next  = (end_x < NUM_X) ? BIT_W'(end_x)
                                                       : BIT_W'(NUM_X - XW'(1));
                            ptr_next = {1'b0, first_x[BIT_W-1:PW]};
                        end
                        ffum_pkg::CMD_CLEAR:
                        begin
                            hi_next   = MAP_TOP;
                            full_next = 1'b1;
                        end
                        default:
                        begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                end
            end
            ffum_pkg::ST_SCAN:
            begin
                if (pend_reg)
                begin
                    carry_next = ev.carry_out;
                    if (ev.hit)
                    begin
                        // run ends at hit_bit; start is eff - 1 units lower
                        lo_next      = BIT_W'(XW'(hit_bit) + XW'(1) - XW'(eff_reg));
                        hi_next      = hit_bit;
                        ptr_next     = {1'b0, lo_next[BIT_W-1:PW]};
                        pend_next    = 1'b0;
                        set_next     = 1'b1;
                        res_ok_next  = 1'b1;
                        res_hit_next = 1'b1;
                    end
                end
            end
            ffum_pkg::ST_SWEEP:
            begin
                if (pend_reg && (eval_ptr_reg == hi_word))
                begin
                    init_next = 1'b0;
                end
            end
            default:
            begin
                init_next = init_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ffum_pkg::ST_SWEEP;
            init_reg     <= 1'b1;
            ptr_reg      <= '0;
            eval_ptr_reg <= '0;
            pend_reg     <= 1'b0;
            carry_reg    <= '0;
            eff_reg      <= CW'(1);
            zero_reg     <= 1'b0;
            lo_reg       <= '0;
            hi_reg       <= MAP_TOP;
            set_reg      <= 1'b0;
            full_reg     <= 1'b1;
            res_ok_reg   <= 1'b0;
            res_hit_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            init_reg     <= init_next;
            ptr_reg      <= ptr_next;
            eval_ptr_reg <= eval_ptr_next;
            pend_reg     <= pend_next;
            carry_reg    <= carry_next;
            eff_reg      <= eff_next;
            zero_reg     <= zero_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            set_reg      <= set_next;
            full_reg     <= full_next;
            res_ok_reg   <= res_ok_next;
            res_hit_reg  <= res_hit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_base_reg <= ffum_pkg::DATA_BASE_RESET;
        end
        else if (cfg_we)
        begin
            data_base_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `FFUM_ASSERT_NXT(a_done_one_cycle, done, !done, "result strobe held past one cycle")
    `FFUM_ASSERT_NXT(a_accept_busy, accept, busy, "accepted request did not raise busy")
    `FFUM_ASSERT_IMP(a_rmw_no_overlap, ram_we && ram_re,
        ptr_reg[ADDR_W-1:0] != eval_ptr_reg, "map read and write hit the same word")
    `FFUM_ASSERT_IMP(a_run_in_map, done && res_hit_reg,
        (XW'(lo_reg) + XW'(eff_reg)) <= NUM_X, "allocated run passes the map end")

endmodule
